// ===== design/rmf_pkg.sv =====
// ----------------------------------------------------------------------------
// rmf_pkg
// Shared constants and types of the running median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rmf_pkg;

  // window depth and sample width
  localparam int WINDOW       = 7;
  localparam int SAMPLE_WIDTH = 16;

  // age of a held sample, 0 for the newest, WINDOW-1 for the oldest
  localparam int AGE_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  // number of held samples, 0 up to WINDOW
  localparam int CNT_W = $clog2(WINDOW + 1);

  localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(WINDOW - 1);

  // what a cell shows its neighbors in the current cycle
  typedef struct packed {
    logic                    keep;    // valid and not leaving the window
    logic                    expire;  // holds the oldest sample of a full window
    logic                    down;    // the leaving sample sits above this cell
    logic                    up;      // the new sample goes above this cell
    logic [AGE_W-1:0]        age;
    logic [SAMPLE_WIDTH-1:0] value;
  } cell_link_t;

endpackage

`default_nettype wire

// ===== design/rmf_cell.sv =====
// ----------------------------------------------------------------------------
// rmf_cell
// One slot of the sorted window: holds a sample and its age, and on each
// accepted word keeps its sample, takes the one of a neighbor, or takes the
// new sample.
// ----------------------------------------------------------------------------
`default_nettype none

module rmf_cell
  import rmf_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    load,
  input  wire logic [SAMPLE_WIDTH-1:0] new_value,
  input  wire logic [SAMPLE_WIDTH-1:0] leave_value,
  input  wire logic                    full,
  input  wire logic                    in_range,
  input  wire cell_link_t              prev_link,
  input  wire cell_link_t              next_link,
  output      cell_link_t              link,
  output      logic                    valid
);

  logic [SAMPLE_WIDTH-1:0] value;
  logic [AGE_W-1:0]        age;

  logic                    take_self;
  logic                    take_prev;
  logic                    take_next;
  logic [SAMPLE_WIDTH-1:0] value_next;
  logic [AGE_W-1:0]        age_next;

  // local compares against the new and the leaving sample
  always_comb begin
    link.value  = value;
    link.age    = age;
    link.expire = valid && full && (age == AGE_OLDEST);
    link.keep   = valid && !link.expire;
    link.up     = !(valid && (value >= new_value));
    link.down   = link.keep && full && (value <= leave_value);
  end

  // pick the source of the next content
  always_comb begin
    take_self = link.keep && (link.down == link.up);
    take_next = next_link.keep && next_link.down && !next_link.up;
    take_prev = prev_link.keep && !prev_link.down && prev_link.up;
    if (take_self) begin
      value_next = value;
      age_next   = age + AGE_W'(1);
    end else if (take_next) begin
      value_next = next_link.value;
      age_next   = next_link.age + AGE_W'(1);
    end else if (take_prev) begin
      value_next = prev_link.value;
      age_next   = prev_link.age + AGE_W'(1);
    end else begin
      value_next = new_value;
      age_next   = '0;
    end
  end

  // slot contents
  always_ff @(posedge clk) begin
    if (load) begin
      value <= value_next;
      age   <= age_next;
    end
  end

  // slot occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= in_range;
    end
  end

endmodule

`default_nettype wire

// ===== design/running_median_filter_top.sv =====
// ----------------------------------------------------------------------------
// running_median_filter_top
// Running median over the last WINDOW samples, kept as a sorted row of cells.
// ----------------------------------------------------------------------------
// The filter takes one sample word per clock cycle unless its output stalls,
// giving a median word for each in the next cycle. The window is held as a
// row of WINDOW cells sorted from largest to smallest, each with the age of
// its sample; on every accepted word each cell compares its sample with the
// new sample and with the oldest one, and in that same cycle the oldest is
// dropped and the new one slotted in while neighbors shift by one place. A
// zero sample counts as one. While the window is still filling, the median of
// the n held samples is the sample at place floor(n/2) from the top. A median
// word that is not taken holds the sample input until it is.
// ----------------------------------------------------------------------------
`default_nettype none

module running_median_filter_top
  import rmf_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [SAMPLE_WIDTH-1:0] sample,
  input  wire logic                    sample_valid,
  output      logic                    sample_ready,
  output      logic [SAMPLE_WIDTH-1:0] median,
  output      logic                    median_valid,
  input  wire logic                    median_ready
);

  logic [CNT_W-1:0]        fill;
  logic [CNT_W-1:0]        fill_next;
  logic [CNT_W-1:0]        half;
  logic                    full;
  logic                    load;
  logic [SAMPLE_WIDTH-1:0] new_value;
  logic [SAMPLE_WIDTH-1:0] leave_value;

  cell_link_t              links [WINDOW];
  logic [WINDOW-1:0]       cell_valid;
  logic [WINDOW-1:0]       cell_expire;

  // handshake
  assign sample_ready = !median_valid || median_ready;
  assign load         = sample_valid && sample_ready;

  // zero reads as one
  assign new_value = (sample == '0) ? SAMPLE_WIDTH'(1) : sample;

  // window fill
  assign full      = (fill == CNT_W'(WINDOW));
  assign fill_next = full ? fill : fill + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (load) begin
      fill <= fill_next;
    end
  end

  // value of the leaving sample, broadcast to all cells
  always_comb begin
    leave_value = '0;
    for (int i = 0; i < WINDOW; i++) begin
      cell_expire[i] = links[i].expire;
      if (links[i].expire) begin
        leave_value = leave_value | links[i].value;
      end
    end
  end

  // row of cells
  for (genvar j = 0; j < WINDOW; j++) begin : g_cell
    cell_link_t prev_link;
    cell_link_t next_link;
    logic       in_range;

    assign in_range = (CNT_W'(j) < fill_next);

    if (j == 0) begin : g_first
      assign prev_link = '0;
    end else begin : g_inner_prev
      assign prev_link = links[j-1];
    end

    if (j == WINDOW - 1) begin : g_last
      assign next_link = '0;
    end else begin : g_inner_next
      assign next_link = links[j+1];
    end

    rmf_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .load        (load),
      .new_value   (new_value),
      .leave_value (leave_value),
      .full        (full),
      .in_range    (in_range),
      .prev_link   (prev_link),
      .next_link   (next_link),
      .link        (links[j]),
      .valid       (cell_valid[j])
    );
  end

  // median word
  assign half   = fill >> 1;
  assign median = links[half[AGE_W-1:0]].value;

  always_ff @(posedge clk) begin
    if (rst) begin
      median_valid <= 1'b0;
    end else if (load) begin
      median_valid <= 1'b1;
    end else if (median_ready) begin
      median_valid <= 1'b0;
    end
  end

  // checks
  a_count_matches_fill : assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(fill))
    else $error("occupied cells differ from fill count");

  a_one_oldest_when_full : assert property (@(posedge clk) disable iff (rst)
    full |-> $onehot(cell_expire))
    else $error("full window without exactly one oldest sample");

  a_median_after_load : assert property (@(posedge clk) disable iff (rst)
    load |=> median_valid)
    else $error("accepted sample gave no median word");

  for (genvar j = 0; j < WINDOW - 1; j++) begin : g_chk
    a_sorted : assert property (@(posedge clk) disable iff (rst)
      cell_valid[j+1] |-> (cell_valid[j] && (links[j].value >= links[j+1].value)))
      else $error("cell row out of order");
  end

endmodule

`default_nettype wire

// ===== dv/running_median_filter_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_median_filter_top_tb
// Self-checking bench for the running median filter.
// ----------------------------------------------------------------------------
// Sample words are driven on the falling edge and both handshakes are watched
// on the rising edge. Every accepted sample goes through a software window of
// the last WINDOW samples, and the median that window predicts is queued. Each
// median word taken from the block is compared with the oldest queued value.
// Directed words cover the filling window, zero and full-scale samples and
// runs of equal values. A long random stream follows, with bursts of idle
// cycles on both sides, one full drain before it and an idle-free tail.
// ----------------------------------------------------------------------------

module running_median_filter_top_tb;
  import rmf_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int REPORT_LIMIT = 10;

  logic                    clk          = 1'b0;
  logic                    rst          = 1'b1;
  logic [SAMPLE_WIDTH-1:0] sample       = '0;
  logic                    sample_valid = 1'b0;
  logic                    sample_ready;
  logic [SAMPLE_WIDTH-1:0] median;
  logic                    median_valid;
  logic                    median_ready = 1'b0;

  // software copy of the window
  logic [SAMPLE_WIDTH-1:0] win_vals [WINDOW];
  int unsigned             win_head  = 0;
  int unsigned             win_count = 0;

  logic [SAMPLE_WIDTH-1:0] median_q [$];
  logic [SAMPLE_WIDTH-1:0] want_median;
  int unsigned             mismatches   = 0;
  int unsigned             stall_cycles = 0;
  int unsigned             rx_hold      = 0;
  bit                      idling_on    = 1'b1;

  running_median_filter_top u_top (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .median       (median),
    .median_valid (median_valid),
    .median_ready (median_ready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // write one sample into the window and rank what it holds
  function automatic logic [SAMPLE_WIDTH-1:0] window_median(
    input logic [SAMPLE_WIDTH-1:0] raw
  );
    logic [SAMPLE_WIDTH-1:0] ranked [WINDOW];
    logic [SAMPLE_WIDTH-1:0] v;
    int                      j;
    v = (raw == '0) ? SAMPLE_WIDTH'(1) : raw;
    win_vals[win_head] = v;
    win_head = (win_head == WINDOW - 1) ? 0 : win_head + 1;
    if (win_count < WINDOW) win_count++;
    // insertion sort, largest first, duplicates kept
    for (int i = 0; i < win_count; i++) begin
      v = win_vals[i];
      j = i;
      while (j > 0 && ranked[j-1] < v) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = v;
    end
    // the ceil((n+1)/2)-th largest sits at index n/2
    return ranked[win_count / 2];
  endfunction

  // predict on each accepted sample, then check each accepted median word
  always @(posedge clk) begin
    if (!rst && sample_valid && sample_ready) begin
      median_q.push_back(window_median(sample));
    end
    if (!rst && median_valid && median_ready) begin
      if (median_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("median word %0d arrived with nothing pending", median);
        end
      end else begin
        want_median = median_q.pop_front();
        if (median !== want_median) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("median mismatch: expected %0d, got %0d", want_median, median);
          end
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((sample_valid && sample_ready) || (median_valid && median_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // output side back-pressure in random bursts
  always @(negedge clk) begin
    if (rx_hold != 0) begin
      median_ready = 1'b0;
      rx_hold--;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      median_ready = 1'b0;
      rx_hold = $urandom_range(0, 6);
    end else begin
      median_ready = 1'b1;
    end
  end

  // drive one sample word and hold it until taken
  task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] value);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    sample       = value;
    sample_valid = 1'b1;
    do @(posedge clk); while (!sample_ready);
    @(negedge clk);
    sample_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (median_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly full-range words, with zeros, small values and extremes mixed in
  function automatic logic [SAMPLE_WIDTH-1:0] random_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1, 2:    return SAMPLE_WIDTH'($urandom_range(0, 7));
      3:       return ($urandom_range(0, 1) != 0) ? '1 : SAMPLE_WIDTH'(1);
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  // window filling from empty, with zero and full-scale words
  task automatic test_fill_window();
    logic [SAMPLE_WIDTH-1:0] seq [7] = '{16'h0000, 16'hffff, 16'h0001, 16'h8000,
                                         16'h7fff, 16'haaaa, 16'h5555};
    foreach (seq[i]) send_sample(seq[i]);
  endtask

  // runs of equal values across the ranking point
  task automatic test_equal_values();
    logic [SAMPLE_WIDTH-1:0] seq [7] = '{16'd5, 16'd5, 16'd5, 16'd9, 16'd9, 16'd2, 16'd2};
    foreach (seq[i]) send_sample(seq[i]);
  endtask

  // full window wrapping through zeros then full-scale words
  task automatic test_wrap_extremes();
    repeat (4) send_sample('0);
    repeat (3) send_sample('1);
  endtask

  // sender holds off until every pending median has come back
  task automatic test_drain_pause();
    repeat (20) send_sample(random_sample());
    wait_drained();
    repeat (20) send_sample(random_sample());
  endtask

  // long random stream, idling switched on and off in stretches
  task automatic test_random_stream(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 100 == 0) idling_on = ($urandom_range(0, 3) != 0);
      send_sample(random_sample());
    end
    idling_on = 1'b1;
  endtask

  // back-to-back words with no idling on either side
  task automatic test_steady_tail();
    idling_on = 1'b0;
    repeat (200) send_sample(random_sample());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_fill_window();
    test_equal_values();
    test_wrap_extremes();
    test_drain_pause();
    test_random_stream(950);
    test_steady_tail();

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
